// ===== design/psg_sdw_pkg.sv =====
// Package for the register shadow and delta writer: shared types, codes and
// the emit slot tables. No dependencies.
`default_nettype none

package psg_sdw_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 10;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned NUM_SLOTS = 12;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_STEREO = 2'd1,
    KIND_EMIT   = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // Slot 0 is the stereo byte; the others carry a register's first or second byte.
  localparam logic [IDX_W-1:0] SLOT_REG [NUM_SLOTS] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7
  };
  localparam logic SLOT_HI [NUM_SLOTS] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0
  };
  localparam logic [SLOT_W-1:0] SLOT_STEREO = 4'd0;

  typedef struct packed {
    logic do_write;
    logic do_stereo;
    logic do_start;
    logic do_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic any_sel;
    logic last_slot;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/psg_register_shadow_delta_writer.sv =====
// Register shadow and delta writer, top level: joins controller and datapath.
// An emit item loads the pending slot mask; the run then puts its bytes (up to twelve) in
// the output register one byte per cycle while the consumer takes them. Throughput: one
// write item per cycle; during an emit run the input is not ready until the last byte
// is loaded. An emit with no changed register starts no run.
// Reset (rst_ni, asynchronous, active low) clears the shadow, the emitted copy and control.
`default_nettype none

module psg_register_shadow_delta_writer
  import psg_sdw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] value_i,
  input  wire logic       full_image_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            is_stereo_o,
  output logic            last_o
);

  // The controller decodes each accepted item and sequences emit runs; the run
  // walks a mask of pending byte slots, lowest first, so no cycle is lost on
  // registers that did not change. The emitted copy is taken whole at the start
  // of a run, since registers that are not selected already match it.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  psg_sdw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psg_sdw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .full_image_i (full_image_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_byte_o   (out_byte_o),
    .is_stereo_o  (is_stereo_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== design/psg_sdw_datapath.sv =====
// Datapath of the register shadow and delta writer: shadow registers, the
// emitted copy, the pending slot mask and the output payload. Uses psg_sdw_pkg.
`default_nettype none

module psg_sdw_datapath
  import psg_sdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  value_i,
  input  wire logic        full_image_i,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_status_t       status_o,
  output logic [7:0]       out_byte_o,
  output logic             is_stereo_o,
  output logic             last_o
);

  logic [REG_W-1:0]     reg_file_q     [NUM_REGS];
  logic [REG_W-1:0]     emitted_regs_q [NUM_REGS];
  logic [IDX_W-1:0]     latched_idx_q;
  logic [7:0]           stereo_q;
  logic [7:0]           emitted_stereo_q;
  logic [NUM_SLOTS-1:0] sel_q, sel_d;
  logic [7:0]           out_byte_q;
  logic                 out_stereo_q;
  logic                 out_last_q;

  logic [NUM_REGS-1:0]  reg_sel;
  logic                 stereo_sel;
  logic [NUM_SLOTS-1:0] pick;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    slot;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic [REG_W-1:0]     rd_val;
  logic                 is_latch;
  logic                 is_tone;
  logic [7:0]           slot_byte;

  // Registers selected for the next emit run.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_sel[i] = full_image_i || (reg_file_q[i] != emitted_regs_q[i]);
    end
    stereo_sel = full_image_i || (stereo_q != emitted_stereo_q);
    sel_d = {reg_sel[7], reg_sel[6], reg_sel[5], reg_sel[4], reg_sel[4], reg_sel[3],
             reg_sel[2], reg_sel[2], reg_sel[1], reg_sel[0], reg_sel[0], stereo_sel};
  end

  // Lowest pending slot goes next.
  always_comb begin
    pick = sel_q & (~sel_q + NUM_SLOTS'(1));
    rest = sel_q & ~pick;
    slot = SLOT_STEREO;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  assign is_latch = value_i[7];
  assign wr_idx   = is_latch ? value_i[6:4] : latched_idx_q;
  assign rd_idx   = cmd_i.do_load ? SLOT_REG[slot] : wr_idx;
  assign rd_val   = reg_file_q[rd_idx];
  assign is_tone  = !wr_idx[0] && (wr_idx != 3'd6);

  always_comb begin
    if (slot == SLOT_STEREO) begin
      slot_byte = stereo_q;
    end else if (SLOT_HI[slot]) begin
      slot_byte = {2'b00, rd_val[9:4]};
    end else begin
      slot_byte = {1'b1, rd_idx[2:1], rd_idx[0], rd_val[3:0]};
    end
  end

  assign status_o.any_sel   = |sel_d;
  assign status_o.last_slot = (rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file_q[i]     <= '0;
        emitted_regs_q[i] <= '0;
      end
      latched_idx_q    <= '0;
      stereo_q         <= '0;
      emitted_stereo_q <= '0;
      sel_q            <= '0;
    end else begin
      if (cmd_i.do_write) begin
        if (is_latch) begin
          latched_idx_q      <= value_i[6:4];
          reg_file_q[wr_idx] <= {rd_val[9:4], value_i[3:0]};
        end else if (is_tone) begin
          reg_file_q[wr_idx] <= {value_i[5:0], rd_val[3:0]};
        end else begin
          reg_file_q[wr_idx] <= {6'd0, value_i[3:0]};
        end
      end
      if (cmd_i.do_stereo) begin
        stereo_q <= value_i;
      end
      // Unselected registers already match, so the whole copy can be taken.
      if (cmd_i.do_start) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          emitted_regs_q[i] <= reg_file_q[i];
        end
        emitted_stereo_q <= stereo_q;
        sel_q            <= sel_d;
      end else if (cmd_i.do_load) begin
        sel_q <= rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load) begin
      out_byte_q   <= slot_byte;
      out_stereo_q <= (slot == SLOT_STEREO);
      out_last_q   <= (rest == '0);
    end
  end

  assign out_byte_o  = out_byte_q;
  assign is_stereo_o = out_stereo_q;
  assign last_o      = out_last_q;

  property p_load_has_pending;
    @(posedge clk_i) disable iff (!rst_ni) cmd_i.do_load |-> (sel_q != '0);
  endproperty
  a_load_has_pending: assert property (p_load_has_pending)
    else $error("byte loaded with no pending slot");

  property p_start_takes_copy;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.do_start |=> (emitted_stereo_q == stereo_q);
  endproperty
  a_start_takes_copy: assert property (p_start_takes_copy)
    else $error("emitted stereo copy not updated at run start");

  property p_one_command;
    @(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd_i);
  endproperty
  a_one_command: assert property (p_one_command)
    else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire

// ===== design/psg_sdw_ctrl.sv =====
// Controller of the register shadow and delta writer: input decode, the run
// state machine and the output valid flag. Uses psg_sdw_pkg.
`default_nettype none

module psg_sdw_ctrl
  import psg_sdw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (kind_i)
            KIND_WRITE:  cmd_o.do_write  = 1'b1;
            KIND_STEREO: cmd_o.do_stereo = 1'b1;
            KIND_EMIT: begin
              cmd_o.do_start = 1'b1;
              if (status_i.any_sel) begin
                state_d = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd_o.do_load = 1'b1;
          if (status_i.last_slot) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.do_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  property p_load_when_free;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.do_load |-> slot_free;
  endproperty
  a_load_when_free: assert property (p_load_when_free)
    else $error("output register overwritten while full");

  property p_start_enters_run;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_o.do_start && status_i.any_sel) |=> (state_q == ST_RUN);
  endproperty
  a_start_enters_run: assert property (p_start_enters_run)
    else $error("emit with changes did not start a run");

  property p_stall_holds_run;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_RUN && !slot_free) |=> (state_q == ST_RUN);
  endproperty
  a_stall_holds_run: assert property (p_stall_holds_run)
    else $error("run left while output stalled");

endmodule

`default_nettype wire
